>>> src/lptt_pkg.sv
package lptt_pkg;

  // Table geometry (slot count is a power of two; home slot is a mask)
  localparam int SLOT_COUNT = 2048;
  localparam int SLOT_BITS  = $clog2(SLOT_COUNT);

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int PID_W = 22;

  // Hash: only product bits below 32 + SLOT_BITS reach the home slot
  localparam logic [63:0] HASH_MUL = 64'h9e37_79b9_7f4a_7c15;
  localparam int PROD_W = 32 + SLOT_BITS;
  localparam int HALF_W = (PROD_W + 1) / 2;
  localparam int HI_W   = PROD_W - HALF_W;
  localparam logic [HALF_W-1:0] MUL_LO = HASH_MUL[HALF_W-1:0];
  localparam logic [HI_W-1:0]   MUL_HI = HASH_MUL[PROD_W-1:HALF_W];

  typedef logic [SLOT_BITS-1:0] slot_t;
  typedef logic [PROD_W-1:0]    prod_t;

  // Commands
  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_LOOKUP = 2'd0;
  localparam cmd_t CMD_INSERT = 2'd1;
  localparam cmd_t CMD_REMOVE = 2'd2;
  localparam cmd_t CMD_CLEAR  = 2'd3;

  // Status codes
  typedef logic [1:0] status_t;
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_NOTFOUND = 2'd1;
  localparam status_t ST_FULL     = 2'd2;
  localparam status_t ST_REJECT   = 2'd3;

  // One slot of the table: handle, data word and home slot of the entry
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    slot_t            home;
  } entry_t;

endpackage

>>> src/linear_probe_task_table_top.sv
// Sequence, accept to out_valid: a rejected command goes straight to S_FIN;
//   lookup or insert: S_HASH1, S_HASH2, then S_PROBE and S_CHK per slot probed;
//   remove scans on behind the hit and closes the hole; clear writes every slot.
// Commands are taken one at a time; the probe loop reads each slot in turn
//   through the single registered read port of the slot memory.
// Reset: synchronous, active low; every slot is then cleared, in_stall high.
module linear_probe_task_table_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_task_handle,
  input  logic [21:0] in_task_pid,
  input  logic [31:0] in_entry_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [31:0] out_read_value
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_HASH1   = 4'd1;
  localparam logic [3:0] S_HASH2   = 4'd2;
  localparam logic [3:0] S_PROBE   = 4'd3;
  localparam logic [3:0] S_CHK     = 4'd4;
  localparam logic [3:0] S_DEL_RD  = 4'd5;
  localparam logic [3:0] S_DEL_CHK = 4'd6;
  localparam logic [3:0] S_DEL_END = 4'd7;
  localparam logic [3:0] S_CLR     = 4'd8;
  localparam logic [3:0] S_FIN     = 4'd9;

  logic [3:0]                       state_r;
  logic                             enable_r;
  logic                             clr_resp_r;
  lptt_pkg::cmd_t                   cmd_r;
  logic [lptt_pkg::KEY_W-1:0]       key_r;
  logic [lptt_pkg::PID_W-1:0]       pid_r;
  logic [lptt_pkg::VAL_W-1:0]       val_r;
  lptt_pkg::slot_t                  home_r;
  lptt_pkg::slot_t                  addr_r;
  lptt_pkg::slot_t                  hole_r;
  lptt_pkg::slot_t                  cnt_r;
  logic [lptt_pkg::PID_W+lptt_pkg::HALF_W-1:0] prod_lo_r;
  logic [lptt_pkg::PID_W+lptt_pkg::HI_W-1:0]   prod_hi_r;
  lptt_pkg::status_t                res_status_r;
  logic [lptt_pkg::VAL_W-1:0]       res_value_r;
  logic                             out_valid_r;
  lptt_pkg::status_t                out_status_r;
  logic [lptt_pkg::VAL_W-1:0]       out_value_r;

  lptt_pkg::entry_t                 mem [lptt_pkg::SLOT_COUNT];
  lptt_pkg::entry_t                 rd_q_r;

  logic                             wr_en;
  lptt_pkg::slot_t                  wr_addr;
  lptt_pkg::entry_t                 wr_data;

  logic [lptt_pkg::PID_W-1:0]       pid_mix;
  lptt_pkg::prod_t                  prod_sum;
  lptt_pkg::slot_t                  home_calc;
  logic                             q_hit;
  logic                             q_empty;
  lptt_pkg::slot_t                  d_hole;
  lptt_pkg::slot_t                  d_j;
  logic                             shift_move;

  // Hash: fold the pid, then two partial products summed in the next cycle
  assign pid_mix   = pid_r ^ (pid_r >> 16);
  assign prod_sum  = lptt_pkg::prod_t'(prod_lo_r)
                   + (lptt_pkg::prod_t'(prod_hi_r) << lptt_pkg::HALF_W);
  assign home_calc = prod_sum[lptt_pkg::SLOT_BITS-1:0]
                   ^ prod_sum[32 +: lptt_pkg::SLOT_BITS];

  // Compare the slot word just read
  assign q_hit   = (rd_q_r.key == key_r);
  assign q_empty = (rd_q_r.key == '0);

  // Backward shift: move the entry if the hole lies nearer its home slot
  assign d_hole     = lptt_pkg::slot_t'(hole_r - rd_q_r.home);
  assign d_j        = lptt_pkg::slot_t'(addr_r - rd_q_r.home);
  assign shift_move = (d_hole < d_j);

  // Memory write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = addr_r;
    wr_data = '0;
    unique case (state_r)
      S_CHK: begin
        if ((q_hit || q_empty) && cmd_r == lptt_pkg::CMD_INSERT) begin
          wr_en         = 1'b1;
          wr_data.key   = key_r;
          wr_data.value = val_r;
          wr_data.home  = home_r;
        end
      end
      S_DEL_CHK: begin
        if (!q_empty && shift_move) begin
          wr_en   = 1'b1;
          wr_addr = hole_r;
          wr_data = rd_q_r;
        end
      end
      S_DEL_END: begin
        wr_en   = 1'b1;
        wr_addr = hole_r;
      end
      S_CLR: begin
        wr_en = 1'b1;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Slot memory: one write, one registered read at the probe address
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q_r <= mem[addr_r];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      addr_r      <= '0;
      clr_resp_r  <= 1'b0;
      enable_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        enable_r <= cfg_wr_data;
      end

      // drop the result word once taken, unless a new one is loaded now
      if (out_valid_r && !out_stall && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r       <= in_command;
            key_r       <= in_task_handle;
            pid_r       <= in_task_pid;
            val_r       <= in_entry_value;
            res_value_r <= '0;
            if (!enable_r) begin
              res_status_r <= lptt_pkg::ST_REJECT;
              state_r      <= S_FIN;
            end else if (in_command == lptt_pkg::CMD_CLEAR) begin
              addr_r     <= '0;
              clr_resp_r <= 1'b1;
              state_r    <= S_CLR;
            end else if (in_task_handle == '0) begin
              res_status_r <= lptt_pkg::ST_REJECT;
              state_r      <= S_FIN;
            end else begin
              state_r <= S_HASH1;
            end
          end
        end
        S_HASH1: begin
          prod_lo_r <= pid_mix * lptt_pkg::MUL_LO;
          prod_hi_r <= pid_mix * lptt_pkg::MUL_HI;
          state_r   <= S_HASH2;
        end
        S_HASH2: begin
          home_r  <= home_calc;
          addr_r  <= home_calc;
          cnt_r   <= '0;
          state_r <= S_PROBE;
        end
        S_PROBE: begin
          state_r <= S_CHK;
        end
        S_CHK: begin
          if (q_hit || q_empty) begin
            if (cmd_r == lptt_pkg::CMD_INSERT) begin
              res_status_r <= lptt_pkg::ST_OK;
              res_value_r  <= val_r;
              state_r      <= S_FIN;
            end else if (!q_hit) begin
              res_status_r <= lptt_pkg::ST_NOTFOUND;
              state_r      <= S_FIN;
            end else if (cmd_r == lptt_pkg::CMD_LOOKUP) begin
              res_status_r <= lptt_pkg::ST_OK;
              res_value_r  <= rd_q_r.value;
              state_r      <= S_FIN;
            end else begin
              hole_r  <= addr_r;
              addr_r  <= lptt_pkg::slot_t'(addr_r + 1'b1);
              cnt_r   <= lptt_pkg::slot_t'(1);
              state_r <= S_DEL_RD;
            end
          end else if (cnt_r == '1) begin
            // every slot probed without a match or a gap
            res_status_r <= (cmd_r == lptt_pkg::CMD_INSERT) ? lptt_pkg::ST_FULL
                                                             : lptt_pkg::ST_NOTFOUND;
            state_r      <= S_FIN;
          end else begin
            cnt_r   <= lptt_pkg::slot_t'(cnt_r + 1'b1);
            addr_r  <= lptt_pkg::slot_t'(addr_r + 1'b1);
            state_r <= S_PROBE;
          end
        end
        S_DEL_RD: begin
          // counter wraps to zero once the whole table is scanned
          state_r <= (cnt_r == '0) ? S_DEL_END : S_DEL_CHK;
        end
        S_DEL_CHK: begin
          if (q_empty) begin
            state_r <= S_DEL_END;
          end else begin
            if (shift_move) begin
              hole_r <= addr_r;
            end
            addr_r  <= lptt_pkg::slot_t'(addr_r + 1'b1);
            cnt_r   <= lptt_pkg::slot_t'(cnt_r + 1'b1);
            state_r <= S_DEL_RD;
          end
        end
        S_DEL_END: begin
          res_status_r <= lptt_pkg::ST_OK;
          state_r      <= S_FIN;
        end
        S_CLR: begin
          addr_r <= lptt_pkg::slot_t'(addr_r + 1'b1);
          if (addr_r == '1) begin
            res_status_r <= lptt_pkg::ST_OK;
            res_value_r  <= '0;
            clr_resp_r   <= 1'b0;
            state_r      <= clr_resp_r ? S_FIN : S_IDLE;
          end
        end
        S_FIN: begin
          // hold until the output register is free
          if (!out_valid_r || !out_stall) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_value_r  <= res_value_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_read_value = out_value_r;

endmodule
